FILE: sv/pfa_pkg.sv
// shared types and constants of the page frame free list allocator
`timescale 1ns / 1ps

package pfa_pkg;

    localparam int unsigned ADDR_W     = 40;
    localparam int unsigned IDX_W      = 14;
    localparam int unsigned PAGES      = 1 << IDX_W;
    localparam int unsigned CNT_W      = IDX_W + 1;
    localparam int unsigned PAGE_SHIFT = 12;
    localparam int unsigned PAGE_BYTES = 1 << PAGE_SHIFT;
    localparam int unsigned RND_W      = ADDR_W + 1 - PAGE_SHIFT;

    typedef enum logic [1:0] {
        OP_INIT  = 2'd0,
        OP_ALLOC = 2'd1,
        OP_FREE  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_OOM      = 2'd1,
        ST_REJECTED = 2'd2,
        ST_SPARE    = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        REG_KERNEL_START = 2'd0,
        REG_KERNEL_END   = 2'd1,
        REG_REGION_LIMIT = 2'd2,
        REG_UNUSED       = 2'd3
    } reg_index_t;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LATCH,
        CMD_POP,
        CMD_OOM,
        CMD_POP_LINK,
        CMD_FREE_CHECK,
        CMD_FREE_PUSH,
        CMD_SPAN,
        CMD_COUNT,
        CMD_WALK,
        CMD_WALK_END,
        CMD_EMIT
    } cmd_t;

    typedef struct packed {
        logic count_zero;
        logic walk_done;
        logic out_free;
    } dp_status_t;

endpackage

FILE: sv/pfa_ctrl.sv
// controller state machine of the page frame allocator
`timescale 1ns / 1ps

module pfa_ctrl
    import pfa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [1:0] op,
    output logic       in_stall,
    input  dp_status_t dp_status,
    output cmd_t       cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_POP,
        S_POP_LINK,
        S_FREE_CHECK,
        S_FREE_PUSH,
        S_SPAN,
        S_COUNT,
        S_WALK,
        S_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        cmd        = CMD_NONE;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd = CMD_LATCH;
                    unique case (op_t'(op))
                        OP_INIT:  state_next = S_SPAN;
                        OP_ALLOC: state_next = S_POP;
                        OP_FREE:  state_next = S_FREE_CHECK;
                        OP_NONE:  state_next = S_EMIT;
                    endcase
                end
            end
            S_POP:
            begin
                if (dp_status.count_zero)
                begin
                    cmd        = CMD_OOM;
                    state_next = S_EMIT;
                end
                else
                begin
                    cmd        = CMD_POP;
                    state_next = S_POP_LINK;
                end
            end
            S_POP_LINK:
            begin
                cmd        = CMD_POP_LINK;
                state_next = S_EMIT;
            end
            S_FREE_CHECK:
            begin
                cmd        = CMD_FREE_CHECK;
                state_next = S_FREE_PUSH;
            end
            S_FREE_PUSH:
            begin
                cmd        = CMD_FREE_PUSH;
                state_next = S_EMIT;
            end
            S_SPAN:
            begin
                cmd        = CMD_SPAN;
                state_next = S_COUNT;
            end
            S_COUNT:
            begin
                cmd        = CMD_COUNT;
                state_next = S_WALK;
            end
            S_WALK:
            begin
                if (dp_status.walk_done)
                begin
                    cmd        = CMD_WALK_END;
                    state_next = S_EMIT;
                end
                else
                begin
                    cmd = CMD_WALK;
                end
            end
            S_EMIT:
            begin
                if (dp_status.out_free)
                begin
                    cmd        = CMD_EMIT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

endmodule

FILE: sv/pfa_datapath.sv
// datapath of the page frame allocator: link memory, list registers, output word
`timescale 1ns / 1ps

module pfa_datapath
    import pfa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cmd_t              cmd,
    output dp_status_t        dp_status,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [ADDR_W-1:0] cfg_data,
    input  logic [ADDR_W-1:0] addr,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [ADDR_W-1:0] page_addr,
    output logic [1:0]        status,
    output logic [CNT_W-1:0]  free_pages
);

    logic [IDX_W-1:0] link_mem [PAGES];

    logic [ADDR_W-1:0] kernel_start_reg;
    logic [ADDR_W-1:0] kernel_end_reg;
    logic [ADDR_W-1:0] region_limit_reg;

    logic [IDX_W-1:0]  head_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [IDX_W-1:0]  link_rd_reg;

    logic [ADDR_W-1:0] addr_reg;
    logic [ADDR_W-1:0] diff_reg;
    logic              reject_reg;
    logic              empty_reg;
    logic [CNT_W-1:0]  walk_idx_reg;
    logic [CNT_W-1:0]  npages_reg;

    logic [ADDR_W-1:0] res_page_reg;
    status_t           res_status_reg;

    logic              out_valid_reg;
    logic [ADDR_W-1:0] out_page_reg;
    status_t           out_status_reg;
    logic [CNT_W-1:0]  out_count_reg;

    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    logic [IDX_W-1:0]  mem_wdata;

    logic [ADDR_W:0]   span_round;
    logic [RND_W-1:0]  span_pages;
    logic [CNT_W-1:0]  npages;
    logic              idx_high;
    logic [IDX_W-1:0]  free_idx;
    logic [IDX_W-1:0]  walk_idx;
    logic [IDX_W-1:0]  walk_link;

    // page count of the region, rounded up and capped
    assign span_round = {1'b0, diff_reg} + (ADDR_W + 1)'(PAGE_BYTES - 1);
    assign span_pages = span_round[ADDR_W:PAGE_SHIFT];

    always_comb
    begin
        if (empty_reg)
        begin
            npages = '0;
        end
        else if (span_pages > RND_W'(PAGES))
        begin
            npages = CNT_W'(PAGES);
        end
        else
        begin
            npages = span_pages[CNT_W-1:0];
        end
    end

    assign idx_high  = |diff_reg[ADDR_W-1:PAGE_SHIFT+IDX_W];
    assign free_idx  = diff_reg[PAGE_SHIFT+IDX_W-1:PAGE_SHIFT];
    assign walk_idx  = walk_idx_reg[IDX_W-1:0];
    assign walk_link = (walk_idx == IDX_W'(PAGES - 1)) ? '0 : walk_idx + 1'b1;

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = walk_idx;
        mem_wdata = walk_link;
        if (cmd == CMD_WALK)
        begin
            mem_we = 1'b1;
        end
        else if (cmd == CMD_FREE_PUSH && !reject_reg && !idx_high)
        begin
            mem_we    = 1'b1;
            mem_waddr = free_idx;
            mem_wdata = head_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            link_mem[mem_waddr] <= mem_wdata;
        end
        if (cmd == CMD_POP)
        begin
            link_rd_reg <= link_mem[head_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kernel_start_reg <= '0;
            kernel_end_reg   <= '0;
            region_limit_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_KERNEL_START: kernel_start_reg <= cfg_data;
                REG_KERNEL_END:   kernel_end_reg   <= cfg_data;
                REG_REGION_LIMIT: region_limit_reg <= cfg_data;
                REG_UNUSED:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            unique case (cmd)
                CMD_POP:
                begin
                    count_reg <= count_reg - 1'b1;
                end
                CMD_POP_LINK:
                begin
                    head_reg <= link_rd_reg;
                end
                CMD_FREE_PUSH:
                begin
                    if (!reject_reg && !idx_high)
                    begin
                        head_reg <= free_idx;
                        if (count_reg < CNT_W'(PAGES))
                        begin
                            count_reg <= count_reg + 1'b1;
                        end
                    end
                end
                CMD_WALK_END:
                begin
                    head_reg  <= '0;
                    count_reg <= npages_reg;
                end
                default:
                begin
                end
            endcase

            if (cmd == CMD_EMIT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd)
            CMD_LATCH:
            begin
                addr_reg       <= addr;
                res_page_reg   <= '0;
                res_status_reg <= ST_OK;
            end
            CMD_POP:
            begin
                res_page_reg <= kernel_end_reg + (ADDR_W'(head_reg) << PAGE_SHIFT);
            end
            CMD_OOM:
            begin
                res_status_reg <= ST_OOM;
            end
            CMD_FREE_CHECK:
            begin
                reject_reg <= (addr_reg < kernel_end_reg) || (addr_reg >= region_limit_reg)
                    || ((addr_reg > kernel_start_reg) && (addr_reg < kernel_end_reg));
                diff_reg   <= addr_reg - kernel_end_reg;
            end
            CMD_FREE_PUSH:
            begin
                if (reject_reg || idx_high)
                begin
                    res_status_reg <= ST_REJECTED;
                end
            end
            CMD_SPAN:
            begin
                empty_reg <= (region_limit_reg <= kernel_end_reg);
                diff_reg  <= region_limit_reg - kernel_end_reg;
            end
            CMD_COUNT:
            begin
                npages_reg   <= npages;
                walk_idx_reg <= '0;
            end
            CMD_WALK:
            begin
                walk_idx_reg <= walk_idx_reg + 1'b1;
            end
            CMD_EMIT:
            begin
                out_page_reg   <= res_page_reg;
                out_status_reg <= res_status_reg;
                out_count_reg  <= count_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign dp_status.count_zero = (count_reg == '0);
    assign dp_status.walk_done  = (walk_idx_reg == npages_reg);
    assign dp_status.out_free   = !out_valid_reg || !out_stall;

    assign out_valid  = out_valid_reg;
    assign page_addr  = out_page_reg;
    assign status     = out_status_reg;
    assign free_pages = out_count_reg;

endmodule

FILE: sv/page_frame_free_list_allocator_core.sv
// top level of the page frame free list allocator
`timescale 1ns / 1ps

// Physical page allocator over an index-linked free list of up to 16384 pages of
// 4 KiB, page i sitting at kernel_end + i * 4096. One word in gives one word out.
// A rebuild links the pages of the region: it writes one link per cycle through
// the single write port of the link memory, and allocate waits on the registered
// read of the head's link. A word also waits while the previous result has not
// been taken. The user must write configuration only while no word is in flight;
// the block does not enforce this.

module page_frame_free_list_allocator_core
    import pfa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [ADDR_W-1:0] cfg_data,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        op,
    input  logic [ADDR_W-1:0] addr,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [ADDR_W-1:0] page_addr,
    output logic [1:0]        status,
    output logic [CNT_W-1:0]  free_pages
);

    cmd_t       cmd;
    dp_status_t dp_status;

    pfa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .op        (op),
        .in_stall  (in_stall),
        .dp_status (dp_status),
        .cmd       (cmd)
    );

    pfa_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .dp_status  (dp_status),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .addr       (addr),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .page_addr  (page_addr),
        .status     (status),
        .free_pages (free_pages)
    );

endmodule

FILE: verif/page_frame_free_list_allocator_core_test.sv
// testbench of the page frame allocator: directed and random words checked against a predictor
`timescale 1ns / 1ps

module page_frame_free_list_allocator_core_test;
    import pfa_pkg::*;

    localparam logic [ADDR_W-1:0] ADDR_MAX       = {ADDR_W{1'b1}};
    localparam int                RANDOM_WORDS   = 520;
    localparam int                WATCHDOG_LIMIT = 200000;
    localparam int                FULL_ALLOCS    = 32;

    typedef struct packed {
        logic [ADDR_W-1:0] page;
        status_t           st;
        logic [CNT_W-1:0]  cnt;
    } page_word_t;

    logic              clk;
    logic              rst_n     = 1'b0;
    logic              cfg_we    = 1'b0;
    logic [1:0]        cfg_index = 2'd0;
    logic [ADDR_W-1:0] cfg_data  = '0;
    logic              in_valid  = 1'b0;
    logic              in_stall;
    logic [1:0]        op        = 2'd0;
    logic [ADDR_W-1:0] addr      = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [ADDR_W-1:0] page_addr;
    logic [1:0]        status;
    logic [CNT_W-1:0]  free_pages;

    page_frame_free_list_allocator_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .op         (op),
        .addr       (addr),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .page_addr  (page_addr),
        .status     (status),
        .free_pages (free_pages)
    );

    // predicted allocator state
    logic [IDX_W-1:0]  link_mem [PAGES];
    logic [IDX_W-1:0]  head_q   = '0;
    logic [CNT_W-1:0]  free_q   = '0;
    logic [ADDR_W-1:0] kstart_q = '0;
    logic [ADDR_W-1:0] kend_q   = '0;
    logic [ADDR_W-1:0] limit_q  = '0;

    page_word_t        predicted_words[$];
    logic [ADDR_W-1:0] held_pages[$];
    int                mismatches  = 0;
    int                idle_cycles = 0;
    int                burst_left  = 0;
    int                stall_mode  = 0;
    int                mode_left   = 0;
    int                run_left    = 0;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic logic [ADDR_W-1:0] rand_addr();
        return ADDR_W'({$urandom, $urandom});
    endfunction

    function automatic void predict_page_op(input op_t kind, input logic [ADDR_W-1:0] a,
                                            output page_word_t w);
        logic [63:0]       npg;
        logic [ADDR_W-1:0] idx;
        w.page = '0;
        w.st   = ST_OK;
        case (kind)
            OP_INIT:
            begin
                npg = 0;
                if (limit_q > kend_q)
                    npg = (64'(limit_q) - 64'(kend_q) + 64'(PAGE_BYTES - 1)) >> PAGE_SHIFT;
                if (npg > PAGES)
                    npg = PAGES;
                for (int i = 0; i < int'(npg); i++)
                    link_mem[i] = IDX_W'(i + 1);
                head_q = '0;
                free_q = CNT_W'(npg);
            end
            OP_ALLOC:
            begin
                if (free_q == 0)
                    w.st = ST_OOM;
                else
                begin
                    w.page = kend_q + (ADDR_W'(head_q) << PAGE_SHIFT);
                    head_q = link_mem[head_q];
                    free_q = free_q - 1'b1;
                end
            end
            OP_FREE:
            begin
                if (a < kend_q || a >= limit_q || (a > kstart_q && a < kend_q))
                    w.st = ST_REJECTED;
                else
                begin
                    idx = (a - kend_q) >> PAGE_SHIFT;
                    if (idx >= PAGES)
                        w.st = ST_REJECTED;
                    else
                    begin
                        link_mem[idx[IDX_W-1:0]] = head_q;
                        head_q = idx[IDX_W-1:0];
                        if (free_q < PAGES)
                            free_q = free_q + 1'b1;
                    end
                end
            end
            default: ;
        endcase
        w.cnt = free_q;
    endfunction

    task automatic send_word(input op_t kind, input logic [ADDR_W-1:0] a);
        page_word_t w;
        int         gap;
        in_valid <= 1'b1;
        op       <= kind;
        addr     <= a;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_page_op(kind, a, w);
        predicted_words.push_back(w);
        if (kind == OP_INIT)
            held_pages.delete();
        else if (kind == OP_ALLOC && w.st == ST_OK)
            held_pages.push_back(w.page);
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(24, 1);
            gap = ($urandom_range(9, 0) < 3) ? 0 : $urandom_range(8, 1);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic drain_pipeline();
        in_valid <= 1'b0;
        while (predicted_words.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic program_regs(input logic [ADDR_W-1:0] ks, input logic [ADDR_W-1:0] ke,
                                input logic [ADDR_W-1:0] rl, input bit poke_spare);
        drain_pipeline();
        if (poke_spare)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= REG_UNUSED;
            cfg_data  <= rand_addr();
            @(posedge clk);
        end
        cfg_we    <= 1'b1;
        cfg_index <= REG_KERNEL_START;
        cfg_data  <= ks;
        @(posedge clk);
        kstart_q = ks;
        cfg_index <= REG_KERNEL_END;
        cfg_data  <= ke;
        @(posedge clk);
        kend_q = ke;
        cfg_index <= REG_REGION_LIMIT;
        cfg_data  <= rl;
        @(posedge clk);
        limit_q = rl;
        cfg_we <= 1'b0;
    endtask

    task automatic test_after_reset();
        send_word(OP_ALLOC, ADDR_MAX);
        send_word(OP_FREE, '0);
        send_word(OP_NONE, ADDR_MAX);
    endtask

    task automatic test_empty_region();
        program_regs('0, '0, '0, 1'b1);
        send_word(OP_INIT, '0);
        send_word(OP_ALLOC, '0);
        program_regs('0, 40'h4000, 40'h3000, 1'b0);
        send_word(OP_INIT, '0);
        send_word(OP_ALLOC, '0);
        send_word(OP_FREE, 40'h3fff);
    endtask

    task automatic test_small_list();
        logic [ADDR_W-1:0] ke;
        ke = 40'h10_0000;
        // four pages, the last one partial
        program_regs(40'h8000, ke, ke + 3 * PAGE_BYTES + 1, 1'b0);
        send_word(OP_INIT, '0);
        repeat (5) send_word(OP_ALLOC, '0);
        send_word(OP_FREE, ke + 2 * PAGE_BYTES + 40'h123);
        send_word(OP_FREE, ke + 2 * PAGE_BYTES);
        send_word(OP_FREE, ke - 1);
        send_word(OP_FREE, ke + 3 * PAGE_BYTES + 1);
        send_word(OP_FREE, 40'h8001);
        send_word(OP_FREE, ke + 3 * PAGE_BYTES);
        repeat (4) send_word(OP_ALLOC, '0);
    endtask

    task automatic test_top_of_space();
        program_regs(ADDR_MAX, ADDR_MAX - 3 * PAGE_BYTES, ADDR_MAX, 1'b0);
        send_word(OP_INIT, '0);
        repeat (3) send_word(OP_ALLOC, '0);
        send_word(OP_FREE, ADDR_MAX - 1);
        send_word(OP_FREE, ADDR_MAX);
        send_word(OP_ALLOC, '0);
        program_regs(ADDR_MAX, ADDR_MAX, ADDR_MAX, 1'b0);
        send_word(OP_INIT, '0);
        send_word(OP_ALLOC, '0);
    endtask

    task automatic test_full_table();
        logic [ADDR_W-1:0] ke;
        ke = 40'h20_0000;
        program_regs('0, ke, ADDR_MAX, 1'b0);
        send_word(OP_INIT, '0);
        // head of the capped list
        for (int k = 0; k < FULL_ALLOCS; k++)
            send_word(OP_ALLOC, rand_addr());
        send_word(OP_ALLOC, '0);
        send_word(OP_INIT, '0);
        send_word(OP_FREE, ke + PAGES * PAGE_BYTES);
        send_word(OP_FREE, ke + 5 * PAGE_BYTES);
        send_word(OP_ALLOC, '0);
        send_word(OP_ALLOC, '0);
    endtask

    task automatic test_random_traffic();
        logic [ADDR_W-1:0] ks, ke, rl, a;
        logic [63:0]       top;
        int                words, span, phase_len, r, pick;
        words = 0;
        while (words < RANDOM_WORDS)
        begin
            r = $urandom_range(99, 0);
            span = (r < 70) ? $urandom_range(40, 1) : (r < 92) ? $urandom_range(300, 41) : 0;
            top = 64'(ADDR_MAX) - 64'(span + 1) * PAGE_BYTES;
            case ($urandom_range(2, 0))
                0:       ke = ADDR_W'($urandom_range(1 << 18, 0)) << PAGE_SHIFT;
                1:       ke = rand_addr();
                default: ke = ADDR_W'(top) - ADDR_W'($urandom_range(9000, 0));
            endcase
            if (64'(ke) > top)
                ke = ADDR_W'(top);
            if (span == 0)
                rl = ke >> $urandom_range(8, 0);
            else
                rl = ke + ADDR_W'(span - 1) * PAGE_BYTES
                     + ADDR_W'($urandom_range(PAGE_BYTES, 1));
            case ($urandom_range(3, 0))
                0:       ks = '0;
                1:       ks = ADDR_MAX;
                2:       ks = rand_addr();
                default: ks = ke >> 1;
            endcase
            program_regs(ks, ke, rl, $urandom_range(3, 0) == 0);
            send_word(OP_INIT, rand_addr());
            words++;
            phase_len = $urandom_range(100, 40);
            for (int k = 0; k < phase_len; k++)
            begin
                r = $urandom_range(99, 0);
                if (r < 40 || (r < 70 && held_pages.size() == 0))
                    send_word(OP_ALLOC, rand_addr());
                else if (r < 70)
                begin
                    pick = $urandom_range(held_pages.size() - 1, 0);
                    a = held_pages[pick];
                    held_pages.delete(pick);
                    if ($urandom_range(2, 0) == 0 && a < ADDR_MAX - PAGE_BYTES)
                        a = a + ADDR_W'($urandom_range(PAGE_BYTES - 1, 1));
                    send_word(OP_FREE, a);
                end
                else if (r < 78)
                begin
                    if (span > 0)
                        a = ke + ADDR_W'($urandom_range(span - 1, 0)) * PAGE_BYTES
                            + ADDR_W'($urandom_range(PAGE_BYTES - 1, 0));
                    else
                        a = rand_addr();
                    send_word(OP_FREE, a);
                end
                else if (r < 90)
                begin
                    case ($urandom_range(4, 0))
                        0:       a = rand_addr();
                        1:       a = ke - 1 - ADDR_W'($urandom_range(5000, 0));
                        2:       a = rl;
                        3:       a = rl - 1;
                        default: a = ks + 1;
                    endcase
                    send_word(OP_FREE, a);
                end
                else if (r < 95)
                    send_word(OP_INIT, rand_addr());
                else
                    send_word(OP_NONE, rand_addr());
                words++;
            end
        end
    endtask

    // receiver back-pressure in changing modes
    always @(posedge clk)
    begin
        if (mode_left == 0)
        begin
            stall_mode <= $urandom_range(3, 0);
            mode_left  <= $urandom_range(200, 20);
        end
        else
            mode_left <= mode_left - 1;
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(3, 0) == 0);
            2: out_stall <= ($urandom_range(9, 0) < 7);
            default:
            begin
                if (run_left == 0)
                begin
                    out_stall <= ~out_stall;
                    run_left  <= $urandom_range(30, 1);
                end
                else
                    run_left <= run_left - 1;
            end
        endcase
    end

    always @(posedge clk)
    begin
        page_word_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (predicted_words.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected word expected none actual %h %h %h",
                         $time, page_addr, status, free_pages);
            end
            else
            begin
                want = predicted_words.pop_front();
                if (page_addr !== want.page || status !== want.st || free_pages !== want.cnt)
                begin
                    mismatches++;
                    if (page_addr !== want.page)
                        $display("%0t: page_addr expected %h actual %h",
                                 $time, want.page, page_addr);
                    if (status !== want.st)
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.st, status);
                    if (free_pages !== want.cnt)
                        $display("%0t: free_pages expected %0d actual %0d",
                                 $time, want.cnt, free_pages);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_after_reset();
        test_empty_region();
        test_small_list();
        test_top_of_space();
        test_full_table();
        test_random_traffic();
        drain_pipeline();
        repeat (50) @(posedge clk);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
